[hdl/spq_pkg.sv]
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Shared types, codes and default sizes for the shift-register priority
// queue and its storage cells.
// ---------------------------------------------------------------------------
package spq_pkg;

    // Default number of entries held by the queue.
    localparam int CAPACITY = 16;

    // Widths of the request and response fields.
    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    // Request modes.
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // One stored pair.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    // Control broadcast to every cell in the row.
    typedef struct packed {
        logic   enq;        // insert the new pair this cycle
        logic   deq;        // shift the row toward the head this cycle
        t_entry new_entry;  // pair being inserted
    } t_cell_ctrl;

endpackage

[hdl/sorted_priority_queue.sv]
// ---------------------------------------------------------------------------
// Sorted priority queue
// Up to CAPACITY (value, priority) pairs kept in a row of cells, sorted by
// descending priority, equal priorities in arrival order.
// ---------------------------------------------------------------------------
// Usage:
// A request on the input channel (i_valid / o_ready) carries a mode, a value
// and a priority. Mode enqueue inserts the pair ahead of the first stored
// entry of strictly lower priority; mode dequeue removes the head entry.
// Every request gives exactly one response on the output channel
// (o_valid / i_ready) with the dequeued value, a status and the occupancy.
// An enqueue into a full queue is dropped with the full status, and a
// dequeue from an empty queue returns zero with the empty status.
// The response is registered at the edge that accepts the request.
// Throughput is one request per cycle while the receiver does not stall,
// since every cell compares against the new priority and shifts in
// parallel. When the receiver stalls, the response register holds and
// o_ready drops until it is taken; a new request is accepted in the same
// cycle that the pending response leaves. Reset empties the queue and
// clears the response valid; stored entries are not cleared.
// ---------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_mode,
    input  logic signed [spq_pkg::DATA_W-1:0] i_item_value,
    input  logic signed [spq_pkg::DATA_W-1:0] i_item_priority,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [spq_pkg::DATA_W-1:0] o_out_value,
    output logic [1:0]                        o_status,
    output logic [spq_pkg::OCC_W-1:0]         o_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic signed [spq_pkg::DATA_W-1:0] r_out_value;
    logic signed [spq_pkg::DATA_W-1:0] n_out_value;
    spq_pkg::t_status     r_status;
    spq_pkg::t_status     n_status;

    logic                 accept;
    logic                 full;
    logic                 empty;
    spq_pkg::t_cell_ctrl  ctrl;
    logic [CAPACITY-1:0]  occupied;
    logic [CAPACITY-1:0]  ins;
    spq_pkg::t_entry      entries [CAPACITY];

    // Handshake: a new request enters whenever the response slot frees up.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign empty   = (r_count == '0);

    // Control broadcast to the row of cells.
    always_comb begin
        ctrl.enq             = accept && (i_mode == spq_pkg::MODE_ENQ) && !full;
        ctrl.deq             = accept && (i_mode == spq_pkg::MODE_DEQ) && !empty;
        ctrl.new_entry.value = i_item_value;
        ctrl.new_entry.prio  = i_item_priority;
    end

    // Row of storage cells; occupancy follows from the entry count.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign occupied[g] = (CNT_W'(g) < r_count);

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_occupied (occupied[g]),
            .i_ins_left ((g == 0) ? 1'b0 : ins[(g == 0) ? 0 : g - 1]),
            .i_left     (entries[(g == 0) ? 0 : g - 1]),
            .i_right    (entries[(g == CAPACITY - 1) ? g : g + 1]),
            .o_ins      (ins[g]),
            .o_entry    (entries[g])
        );
    end

    // Entry count and response for the accepted request.
    always_comb begin
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_ready;
        n_out_value = r_out_value;
        n_status    = r_status;
        if (accept) begin
            n_out_valid = 1'b1;
            n_out_value = '0;
            if (i_mode == spq_pkg::MODE_ENQ) begin
                if (full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_status = spq_pkg::ST_ENQUEUED;
                    n_count  = r_count + 1'b1;
                end
            end else begin
                if (empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_status    = spq_pkg::ST_DEQUEUED;
                    n_out_value = entries[0].value;
                    n_count     = r_count - 1'b1;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Response payload registers.
    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
        r_status    <= n_status;
    end

    logic [spq_pkg::OCC_W-1:0] r_occupancy;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_occupancy <= spq_pkg::OCC_W'(n_count);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_status    = r_status;
    assign o_occupancy = r_occupancy;

    // The entry count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A dequeue from an empty queue reports empty and leaves the count.
    a_empty_deq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == spq_pkg::MODE_DEQ && empty) |=>
            (o_valid && o_status == spq_pkg::ST_EMPTY && $stable(r_count)))
        else $error("empty dequeue mishandled");

    // An enqueue into a full queue is dropped and leaves the count.
    a_full_enq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_mode == spq_pkg::MODE_ENQ && full) |=>
            (o_valid && o_status == spq_pkg::ST_FULL && $stable(r_count)))
        else $error("full enqueue mishandled");

    // Only a successful dequeue returns a nonzero value.
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != spq_pkg::ST_DEQUEUED) |-> (o_out_value == '0))
        else $error("nonzero value without a dequeue");

endmodule

[hdl/spq_cell.sv]
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry of the sorted row; on an insert it keeps, loads the new
// pair or takes its left neighbor, on a removal it takes its right neighbor.
// ---------------------------------------------------------------------------
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occupied,
    input  logic                i_ins_left,
    input  spq_pkg::t_entry     i_left,
    input  spq_pkg::t_entry     i_right,
    output logic                o_ins,
    output spq_pkg::t_entry     o_entry
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // The new pair belongs at or before this cell when the cell is empty or
    // holds a strictly lower priority.
    assign o_ins = i_occupied ? (r_entry.prio < i_ctrl.new_entry.prio) : 1'b1;

    // Select the next content of the cell.
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq && o_ins) begin
            // The first inserting cell takes the new pair, the rest shift back.
            n_entry = i_ins_left ? i_left : i_ctrl.new_entry;
        end else if (i_ctrl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
